@@ rtl/audio_noise_gate_assert.svh @@
// ============================================================================
// Assertion macros for the noise gate
// Clocked checks used by the gain engine module, disabled during reset.
// ============================================================================
`ifndef AUDIO_NOISE_GATE_ASSERT_SVH
`define AUDIO_NOISE_GATE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ANG_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("noise gate check failed");

// antecedent implies consequent in the same cycle
`define ANG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("noise gate check failed");

`endif

@@ rtl/ang_pkg.sv @@
// ============================================================================
// Noise gate package
// Shared constants, register indexes and types of the noise gate.
// ============================================================================
package ang_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int HOLD_BITS_DEF   = 20;
	localparam int QUEUE_DEPTH     = 2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_THRESHOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES    = 3'd5;

	localparam logic        RST_GATE_ENABLE     = 1'b0;
	localparam logic [15:0] RST_OPEN_THRESHOLD  = 16'd328;
	localparam logic [15:0] RST_CLOSE_THRESHOLD = 16'd164;
	localparam logic [15:0] RST_ATTACK_COEFF    = 16'd64186;
	localparam logic [15:0] RST_RELEASE_COEFF   = 16'd65509;
	localparam int          RST_HOLD_SAMPLES    = 2400;

	localparam logic [15:0] ENV_ONE      = 16'd32768;
	localparam logic [15:0] ATTACK_SNAP  = 16'd32736;
	localparam logic [15:0] RELEASE_SNAP = 16'd32;

	localparam logic [2:0] MODE_CLOSED  = 3'd0;
	localparam logic [2:0] MODE_ATTACK  = 3'd1;
	localparam logic [2:0] MODE_OPEN    = 3'd2;
	localparam logic [2:0] MODE_HOLD    = 3'd3;
	localparam logic [2:0] MODE_RELEASE = 3'd4;

	typedef struct packed {
		logic bypass;
		logic above_open;
		logic below_close;
	} ang_cls_t;

	localparam int CLS_W = $bits(ang_cls_t);

endpackage

@@ rtl/ang_front.sv @@
// ============================================================================
// Noise gate front end
// Accepts samples, takes the magnitude and classifies it against the
// thresholds, then pushes the word into the queue.
// ============================================================================
module ang_front #(
	parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          gate_enable,
	input  logic [15:0]                   open_threshold,
	input  logic [15:0]                   close_threshold,
	input  logic                          q_full,
	output logic                          push,
	output logic signed [SAMPLE_BITS-1:0] push_sample,
	output ang_pkg::ang_cls_t             push_cls
);

	localparam int CMP_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

	logic                          vld_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	ang_pkg::ang_cls_t             cls_s1;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [CMP_W-1:0]              mag_x;
	ang_pkg::ang_cls_t             cls;
	logic                          load;

	assign mag   = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample) : SAMPLE_BITS'(in_sample);
	assign mag_x = CMP_W'(mag);

	always_comb begin
		cls.bypass      = !gate_enable;
		cls.above_open  = mag_x >= CMP_W'(open_threshold);
		cls.below_close = mag_x < CMP_W'(close_threshold);
	end

	assign push     = vld_s1 && !q_full;
	assign in_stall = vld_s1 && q_full;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			smp_s1 <= in_sample;
			cls_s1 <= cls;
		end
	end

	assign push_sample = smp_s1;
	assign push_cls    = cls_s1;

endmodule

@@ rtl/ang_queue.sv @@
// ============================================================================
// Noise gate queue
// Short FIFO between the front end and the gain engine.
// ============================================================================
module ang_queue #(
	parameter int WIDTH = ang_pkg::SAMPLE_BITS_DEF + ang_pkg::CLS_W,
	parameter int DEPTH = ang_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/ang_back.sv @@
// ============================================================================
// Noise gate gain engine
// Steps the gate state machine, updates envelope and hold count and applies
// the gain, except in bypass, and holds the result in the output register.
// ============================================================================
`include "audio_noise_gate_assert.svh"

module ang_back #(
	parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF,
	parameter int HOLD_BITS   = ang_pkg::HOLD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic signed [SAMPLE_BITS-1:0] q_sample,
	input  ang_pkg::ang_cls_t             q_cls,
	output logic                          pop,
	input  logic [15:0]                   attack_coeff,
	input  logic [15:0]                   release_coeff,
	input  logic [HOLD_BITS-1:0]          hold_samples,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_sample
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_UPD  = 3'd2;
	localparam logic [2:0] B_GAIN = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	localparam logic [2:0] M_CLOSED  = ang_pkg::MODE_CLOSED;
	localparam logic [2:0] M_ATTACK  = ang_pkg::MODE_ATTACK;
	localparam logic [2:0] M_OPEN    = ang_pkg::MODE_OPEN;
	localparam logic [2:0] M_HOLD    = ang_pkg::MODE_HOLD;
	localparam logic [2:0] M_RELEASE = ang_pkg::MODE_RELEASE;

	localparam int GAIN_W = SAMPLE_BITS + 17;

	logic [2:0]                    st_q;
	logic [2:0]                    mode_q;
	logic [15:0]                   env_q;
	logic [HOLD_BITS-1:0]          rem_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	ang_pkg::ang_cls_t             cls_q;
	logic [31:0]                   prod_q;
	logic signed [GAIN_W-1:0]      gain_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	logic        out_free;
	logic        finish;
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [15:0] prod_hi;
	logic [15:0] env_att;

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (st_q == B_OUT) && out_free;
	assign pop      = !q_empty && ((st_q == B_IDLE) || finish);

	assign mul_a   = (mode_q == M_ATTACK) ? ang_pkg::ENV_ONE - env_q : env_q;
	assign mul_b   = (mode_q == M_ATTACK) ? attack_coeff : release_coeff;
	assign prod_hi = prod_q[31:16];
	assign env_att = ang_pkg::ENV_ONE - prod_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			unique case (st_q)
				B_IDLE: begin
					if (pop) st_q <= B_MUL;
				end
				B_MUL:  st_q <= B_UPD;
				B_UPD:  st_q <= B_GAIN;
				B_GAIN: st_q <= B_OUT;
				B_OUT: begin
					if (finish) st_q <= pop ? B_MUL : B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_CLOSED;
			env_q  <= '0;
			rem_q  <= '0;
		end else if (st_q == B_UPD && !cls_q.bypass) begin
			unique case (mode_q)
				M_ATTACK: begin
					if (env_att >= ang_pkg::ATTACK_SNAP) begin
						env_q  <= ang_pkg::ENV_ONE;
						mode_q <= M_OPEN;
					end else begin
						env_q <= env_att;
					end
				end
				M_OPEN: begin
					if (cls_q.below_close) begin
						mode_q <= M_HOLD;
						rem_q  <= hold_samples;
					end
				end
				M_HOLD: begin
					if (rem_q != '0) rem_q <= rem_q - 1'b1;
					if (cls_q.above_open) begin
						mode_q <= M_OPEN;
					end else if (rem_q <= HOLD_BITS'(1)) begin
						mode_q <= M_RELEASE;
					end
				end
				M_RELEASE: begin
					if (prod_hi <= ang_pkg::RELEASE_SNAP) begin
						env_q  <= '0;
						mode_q <= M_CLOSED;
					end else begin
						env_q <= prod_hi;
						if (cls_q.above_open) mode_q <= M_ATTACK;
					end
				end
				default: begin
					mode_q <= cls_q.above_open ? M_ATTACK : M_CLOSED;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			smp_q <= q_sample;
			cls_q <= q_cls;
		end
		if (st_q == B_MUL) begin
			prod_q <= 32'(mul_a) * 32'(mul_b);
		end
		if (st_q == B_GAIN) begin
			gain_q <= GAIN_W'(smp_q) * $signed(GAIN_W'({1'b0, env_q}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_sample_q <= cls_q.bypass ? smp_q : gain_q[SAMPLE_BITS+14:15];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	`ANG_ASSERT(a_env_max, env_q <= ang_pkg::ENV_ONE)
	`ANG_ASSERT_IMP(a_closed_env, mode_q == M_CLOSED, env_q == '0)
	`ANG_ASSERT_IMP(a_open_env, mode_q == M_OPEN || mode_q == M_HOLD, env_q == ang_pkg::ENV_ONE)
	`ANG_ASSERT_IMP(a_pop_state, pop, st_q == B_IDLE || st_q == B_OUT)

endmodule

@@ rtl/audio_noise_gate.sv @@
// ============================================================================
// Audio noise gate
// Noise gate with attack, hold and release on a Q1.15 sample stream.
// ============================================================================
// Usage:
//   in_valid/in_stall carries one signed sample per word; out_valid/out_stall
//   returns one gated sample per word, in order. A word moves at a clock edge
//   with valid high and stall low.
//   cfg_valid/cfg_ready writes register cfg_index with cfg_data; cfg_ready is
//   always high. Write registers only while no sample is in flight.
//   Path: front register, queue, then four engine steps (multiply, update,
//   gain, output) into the output register. The engine steps share one
//   state machine and carry one sample at a time, so the engine takes a
//   new sample only after the output step of the last one.
//   A two-word queue lets the front keep accepting while the engine or the
//   output register waits. When out_stall is high the output word holds,
//   the engine stops at its output step, then queue and in_stall back up.
//   Reset: registers take their default values, the gate is closed with
//   zero envelope, and all pipeline and queue contents are dropped.
// ============================================================================
module audio_noise_gate #(
	parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF,
	parameter int HOLD_BITS   = ang_pkg::HOLD_BITS_DEF,
	parameter int CFG_W       = (HOLD_BITS > 16) ? HOLD_BITS : 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ang_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	localparam int QW = SAMPLE_BITS + ang_pkg::CLS_W;

	logic                 gate_enable_q;
	logic [15:0]          open_threshold_q;
	logic [15:0]          close_threshold_q;
	logic [15:0]          attack_coeff_q;
	logic [15:0]          release_coeff_q;
	logic [HOLD_BITS-1:0] hold_samples_q;

	logic                          push;
	logic signed [SAMPLE_BITS-1:0] push_sample;
	ang_pkg::ang_cls_t             push_cls;
	logic                          pop;
	logic [QW-1:0]                 pop_data;
	logic                          q_full;
	logic                          q_empty;
	ang_pkg::ang_cls_t             pop_cls;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_enable_q     <= ang_pkg::RST_GATE_ENABLE;
			open_threshold_q  <= ang_pkg::RST_OPEN_THRESHOLD;
			close_threshold_q <= ang_pkg::RST_CLOSE_THRESHOLD;
			attack_coeff_q    <= ang_pkg::RST_ATTACK_COEFF;
			release_coeff_q   <= ang_pkg::RST_RELEASE_COEFF;
			hold_samples_q    <= HOLD_BITS'(ang_pkg::RST_HOLD_SAMPLES);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ang_pkg::REG_GATE_ENABLE:     gate_enable_q     <= cfg_data[0];
				ang_pkg::REG_OPEN_THRESHOLD:  open_threshold_q  <= cfg_data[15:0];
				ang_pkg::REG_CLOSE_THRESHOLD: close_threshold_q <= cfg_data[15:0];
				ang_pkg::REG_ATTACK_COEFF:    attack_coeff_q    <= cfg_data[15:0];
				ang_pkg::REG_RELEASE_COEFF:   release_coeff_q   <= cfg_data[15:0];
				ang_pkg::REG_HOLD_SAMPLES:    hold_samples_q    <= cfg_data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	ang_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_sample      (in_sample),
		.gate_enable    (gate_enable_q),
		.open_threshold (open_threshold_q),
		.close_threshold(close_threshold_q),
		.q_full         (q_full),
		.push           (push),
		.push_sample    (push_sample),
		.push_cls       (push_cls)
	);

	ang_queue #(
		.WIDTH(QW),
		.DEPTH(ang_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_cls, push_sample}),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign pop_cls = pop_data[QW-1:SAMPLE_BITS];

	ang_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.HOLD_BITS  (HOLD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_sample     (pop_data[SAMPLE_BITS-1:0]),
		.q_cls        (pop_cls),
		.pop          (pop),
		.attack_coeff (attack_coeff_q),
		.release_coeff(release_coeff_q),
		.hold_samples (hold_samples_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_sample   (out_sample)
	);

endmodule
